[sv/jard_pkg.sv]
// Shared constants and the byte decode function of the joystick and accelerometer
// report decoder. It depends on nothing else.
`default_nettype none

package jard_pkg;

   // Every raw byte is decoded with this key.
   localparam logic [7:0] DECODE_KEY = 8'h17;

   // Six bytes make one report.
   localparam int FRAME_LEN  = 6;
   localparam int HELD_DEPTH = FRAME_LEN - 1;
   localparam int INDEX_W    = $clog2(FRAME_LEN);

   localparam logic [INDEX_W-1:0] LAST_INDEX = INDEX_W'(FRAME_LEN - 1);

   // A decoded byte is (raw xor key) + key, modulo 256.
   function automatic logic [7:0] decode_byte(input logic [7:0] raw);
      return (raw ^ DECODE_KEY) + DECODE_KEY;
   endfunction

endpackage

`default_nettype wire

[sv/joystick_accel_report_decoder.sv]
// Top level of the joystick and accelerometer report decoder.
// It depends on jard_pkg for the decode key, the frame length and the decode function.
`default_nettype none

// The block takes encoded report bytes, one per transfer on the req_ channel, and
// gives one report on the rsp_ channel for each complete six-byte frame. Each
// byte is decoded as (raw xor 0x17) + 0x17, modulo 256. Bytes 0 and 1 are the
// joystick axes. Bytes 2 to 4 are the upper eight bits of the three accelerometer
// axes, and byte 5 carries their low bits and the z and c buttons. A byte with
// req_frame_start high is taken as byte 0 of a new frame, and a partial frame is
// dropped. Frames may also follow each other without the flag. rsp_changed is
// high when any field differs from the previous report, which reset clears to
// zero. A byte can be accepted on every clock unless the block stops, as below. A
// byte is held in an input register, where it is decoded, and from there it is
// written into the frame buffer or turned into a report in the output register.
// A report is therefore valid once its sixth byte has moved from the input
// register into the output register.
// The block stops taking bytes only when a finished report waits at the output
// and the byte in the input register would complete the next one.
module joystick_accel_report_decoder (
   input  wire logic       clock,
   input  wire logic       reset,

   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_raw_byte,
   input  wire logic       req_frame_start,

   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_joy_x,
   output logic [7:0]      rsp_joy_y,
   output logic [9:0]      rsp_accel_x,
   output logic [9:0]      rsp_accel_y,
   output logic [9:0]      rsp_accel_z,
   output logic            rsp_z_pressed,
   output logic            rsp_c_pressed,
   output logic            rsp_changed
);

   localparam int IW = jard_pkg::INDEX_W;

   // Input register.
   logic       s1_valid_ff, s1_valid_in;
   logic [7:0] s1_raw_ff;
   logic       s1_start_ff;

   // Frame state.
   logic [IW-1:0] byte_index_ff, byte_index_in;
   logic [7:0]    held_ff [jard_pkg::HELD_DEPTH];

   // Previous report, used for the changed flag.
   logic [7:0] prev_joy_x_ff, prev_joy_y_ff;
   logic [9:0] prev_accel_x_ff, prev_accel_y_ff, prev_accel_z_ff;
   logic [1:0] prev_buttons_ff;

   // Output register.
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] joy_x_ff, joy_y_ff;
   logic [9:0] accel_x_ff, accel_y_ff, accel_z_ff;
   logic [1:0] buttons_ff;
   logic       changed_ff;

   // Decode of the byte in the input register.
   logic [7:0]    dec_byte;
   logic [IW-1:0] pos;
   logic          is_last;
   logic          s1_advance;
   logic          report_load;
   logic          req_take;

   logic [7:0] joy_x_in, joy_y_in;
   logic [9:0] accel_x_in, accel_y_in, accel_z_in;
   logic [1:0] buttons_in;
   logic       changed_in;

   always_comb begin
      dec_byte = jard_pkg::decode_byte(s1_raw_ff);
      pos      = s1_start_ff ? '0 : byte_index_ff;
      is_last  = (pos == jard_pkg::LAST_INDEX);

      // A byte that completes a report needs room in the output register; any other
      // byte only writes the frame buffer and moves on at once.
      s1_advance  = s1_valid_ff && (!is_last || !rsp_valid_ff || rsp_ready);
      report_load = s1_advance && is_last;

      req_ready = !s1_valid_ff || s1_advance;
      req_take  = req_valid && req_ready;

      s1_valid_in = req_take ? 1'b1 : (s1_advance ? 1'b0 : s1_valid_ff);

      byte_index_in = byte_index_ff;
      if (s1_advance) begin
         byte_index_in = is_last ? '0 : IW'(pos + 1'b1);
      end

      // The status byte supplies two low bits for each axis: the lower bit position
      // becomes bit 1 and the upper one bit 0.
      joy_x_in   = held_ff[0];
      joy_y_in   = held_ff[1];
      accel_x_in = {held_ff[2], dec_byte[2], dec_byte[3]};
      accel_y_in = {held_ff[3], dec_byte[4], dec_byte[5]};
      accel_z_in = {held_ff[4], dec_byte[6], dec_byte[7]};
      buttons_in = dec_byte[1:0];

      changed_in = (joy_x_in != prev_joy_x_ff) || (joy_y_in != prev_joy_y_ff) ||
                   (accel_x_in != prev_accel_x_ff) || (accel_y_in != prev_accel_y_ff) ||
                   (accel_z_in != prev_accel_z_ff) || (buttons_in != prev_buttons_ff);

      rsp_valid_in = report_load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   // Control state and the previous report, which starts at zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff     <= 1'b0;
         byte_index_ff   <= '0;
         rsp_valid_ff    <= 1'b0;
         prev_joy_x_ff   <= '0;
         prev_joy_y_ff   <= '0;
         prev_accel_x_ff <= '0;
         prev_accel_y_ff <= '0;
         prev_accel_z_ff <= '0;
         prev_buttons_ff <= '0;
      end else begin
         s1_valid_ff   <= s1_valid_in;
         byte_index_ff <= byte_index_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (report_load) begin
            prev_joy_x_ff   <= joy_x_in;
            prev_joy_y_ff   <= joy_y_in;
            prev_accel_x_ff <= accel_x_in;
            prev_accel_y_ff <= accel_y_in;
            prev_accel_z_ff <= accel_z_in;
            prev_buttons_ff <= buttons_in;
         end
      end
   end

   // Payload registers need no reset.
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_raw_ff   <= req_raw_byte;
         s1_start_ff <= req_frame_start;
      end
      if (s1_advance && !is_last) begin
         held_ff[pos] <= dec_byte;
      end
      if (report_load) begin
         joy_x_ff   <= joy_x_in;
         joy_y_ff   <= joy_y_in;
         accel_x_ff <= accel_x_in;
         accel_y_ff <= accel_y_in;
         accel_z_ff <= accel_z_in;
         buttons_ff <= buttons_in;
         changed_ff <= changed_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_joy_x     = joy_x_ff;
   assign rsp_joy_y     = joy_y_ff;
   assign rsp_accel_x   = accel_x_ff;
   assign rsp_accel_y   = accel_y_ff;
   assign rsp_accel_z   = accel_z_ff;
   assign rsp_z_pressed = buttons_ff[0];
   assign rsp_c_pressed = buttons_ff[1];
   assign rsp_changed   = changed_ff;

endmodule

`default_nettype wire

[sv/jard_checker.sv]
// Port-level checker of the joystick and accelerometer report decoder, and its bind.
// It depends on jard_pkg for the frame length.
`default_nettype none

module jard_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic       req_frame_start,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [7:0] rsp_joy_x,
   input wire logic [7:0] rsp_joy_y,
   input wire logic [9:0] rsp_accel_x,
   input wire logic [9:0] rsp_accel_y,
   input wire logic [9:0] rsp_accel_z,
   input wire logic       rsp_z_pressed,
   input wire logic       rsp_c_pressed,
   input wire logic       rsp_changed
);

   localparam int IW = jard_pkg::INDEX_W;

   logic [IW-1:0] pos_ff, pos_in, cur_pos;
   logic [1:0]    pending_ff, pending_in;
   logic          req_xfer, rsp_xfer, frame_done;

   logic [7:0] last_joy_x_ff, last_joy_y_ff;
   logic [9:0] last_accel_x_ff, last_accel_y_ff, last_accel_z_ff;
   logic [1:0] last_buttons_ff;
   logic       differs;

   always_comb begin
      req_xfer   = req_valid && req_ready;
      rsp_xfer   = rsp_valid && rsp_ready;
      cur_pos    = req_frame_start ? '0 : pos_ff;
      frame_done = req_xfer && (cur_pos == jard_pkg::LAST_INDEX);
      pos_in     = pos_ff;
      if (req_xfer) begin
         pos_in = frame_done ? '0 : IW'(cur_pos + 1'b1);
      end
      pending_in = pending_ff + 2'(frame_done) - 2'(rsp_xfer);
      differs = (rsp_joy_x != last_joy_x_ff) || (rsp_joy_y != last_joy_y_ff) ||
                (rsp_accel_x != last_accel_x_ff) || (rsp_accel_y != last_accel_y_ff) ||
                (rsp_accel_z != last_accel_z_ff) ||
                ({rsp_c_pressed, rsp_z_pressed} != last_buttons_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff          <= '0;
         pending_ff      <= '0;
         last_joy_x_ff   <= '0;
         last_joy_y_ff   <= '0;
         last_accel_x_ff <= '0;
         last_accel_y_ff <= '0;
         last_accel_z_ff <= '0;
         last_buttons_ff <= '0;
      end else begin
         pos_ff     <= pos_in;
         pending_ff <= pending_in;
         if (rsp_xfer) begin
            last_joy_x_ff   <= rsp_joy_x;
            last_joy_y_ff   <= rsp_joy_y;
            last_accel_x_ff <= rsp_accel_x;
            last_accel_y_ff <= rsp_accel_y;
            last_accel_z_ff <= rsp_accel_z;
            last_buttons_ff <= {rsp_c_pressed, rsp_z_pressed};
         end
      end
   end

   // A report is never delivered before its sixth byte has been taken.
   assert property (@(posedge clock) disable iff (reset) rsp_xfer |-> pending_ff != 2'd0)
      else $error("report delivered without a completed frame");

   // The decoder holds at most two finished frames: one at the output, one behind it.
   assert property (@(posedge clock) disable iff (reset) pending_ff != 2'd3)
      else $error("more than two reports outstanding");

   // The changed flag agrees with the last delivered report.
   assert property (@(posedge clock) disable iff (reset) rsp_xfer |-> rsp_changed == differs)
      else $error("changed flag disagrees with the previous report");

   // A stalled report keeps its valid, its axis values and its changed flag.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_joy_x) && $stable(rsp_joy_y) &&
      $stable(rsp_accel_x) && $stable(rsp_accel_y) && $stable(rsp_accel_z) &&
      $stable(rsp_changed))
      else $error("stalled report changed");

endmodule

bind joystick_accel_report_decoder jard_checker u_jard_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .req_frame_start (req_frame_start),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_joy_x       (rsp_joy_x),
   .rsp_joy_y       (rsp_joy_y),
   .rsp_accel_x     (rsp_accel_x),
   .rsp_accel_y     (rsp_accel_y),
   .rsp_accel_z     (rsp_accel_z),
   .rsp_z_pressed   (rsp_z_pressed),
   .rsp_c_pressed   (rsp_c_pressed),
   .rsp_changed     (rsp_changed)
);

`default_nettype wire

[test/joystick_accel_report_decoder_tb.sv]
// Self-checking testbench for joystick_accel_report_decoder: sends encoded report bytes,
// predicts every six-byte report, and checks each report that the block returns.
// It depends on jard_pkg for the decode key and the frame length, and on the RTL only.
`default_nettype none

module joystick_accel_report_decoder_tb;
   timeunit 1ns;
   timeprecision 1ps;

   // One decoded report, in the order of the response ports.
   typedef struct packed {
      logic [7:0] joy_x;
      logic [7:0] joy_y;
      logic [9:0] accel_x;
      logic [9:0] accel_y;
      logic [9:0] accel_z;
      logic       z_pressed;
      logic       c_pressed;
      logic       changed;
   } report_type;

   // The scoreboard keeps its own copy of the frame buffer, the byte position and the
   // previous report. Every byte transfer on the request side goes through
   // note_byte, which queues a report when the byte completes a frame. Every
   // response transfer goes through check_report against the oldest queued report.
   class scoreboard_type;
      logic [7:0] frame_bytes [5];
      logic [2:0] position;
      report_type last_report;
      report_type expected_reports [$];
      int         failures;

      function new();
         position    = '0;
         last_report = '0;
         failures    = 0;
         foreach (frame_bytes[i]) frame_bytes[i] = '0;
      endfunction

      function void note_byte(logic [7:0] raw, logic first);
         logic [7:0] plain;
         int         slot;
         report_type rpt;
         plain = (raw ^ jard_pkg::DECODE_KEY) + jard_pkg::DECODE_KEY;
         // A frame start forces the byte to position 0 and drops a partial frame.
         slot = first ? 0 : int'(position);
         if (slot < jard_pkg::FRAME_LEN - 1) begin
            frame_bytes[slot] = plain;
            position = 3'(slot + 1);
            return;
         end
         // The sixth byte is the status byte: the low accelerometer bits sit in
         // pairs above the two button bits, the lower bit position weighing 2.
         position      = '0;
         rpt.joy_x     = frame_bytes[0];
         rpt.joy_y     = frame_bytes[1];
         rpt.accel_x   = {frame_bytes[2], plain[2], plain[3]};
         rpt.accel_y   = {frame_bytes[3], plain[4], plain[5]};
         rpt.accel_z   = {frame_bytes[4], plain[6], plain[7]};
         rpt.z_pressed = plain[0];
         rpt.c_pressed = plain[1];
         rpt.changed   = (rpt.joy_x != last_report.joy_x) ||
                         (rpt.joy_y != last_report.joy_y) ||
                         (rpt.accel_x != last_report.accel_x) ||
                         (rpt.accel_y != last_report.accel_y) ||
                         (rpt.accel_z != last_report.accel_z) ||
                         (rpt.z_pressed != last_report.z_pressed) ||
                         (rpt.c_pressed != last_report.c_pressed);
         last_report = rpt;
         expected_reports.push_back(rpt);
      endfunction

      function void check_report(report_type seen);
         report_type want;
         if (expected_reports.size() == 0) begin
            failures++;
            if (failures <= 10)
               $display({"%0t: report with none expected: ",
                         "jx=%h jy=%h ax=%h ay=%h az=%h z=%b c=%b ch=%b"},
                        $realtime, seen.joy_x, seen.joy_y, seen.accel_x, seen.accel_y,
                        seen.accel_z, seen.z_pressed, seen.c_pressed, seen.changed);
            return;
         end
         want = expected_reports.pop_front();
         if (seen !== want) begin
            failures++;
            if (failures <= 10) begin
               $display("%0t: report mismatch", $realtime);
               $display("   expected jx=%h jy=%h ax=%h ay=%h az=%h z=%b c=%b ch=%b",
                        want.joy_x, want.joy_y, want.accel_x, want.accel_y, want.accel_z,
                        want.z_pressed, want.c_pressed, want.changed);
               $display("   actual   jx=%h jy=%h ax=%h ay=%h az=%h z=%b c=%b ch=%b",
                        seen.joy_x, seen.joy_y, seen.accel_x, seen.accel_y, seen.accel_z,
                        seen.z_pressed, seen.c_pressed, seen.changed);
            end
         end
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_raw_byte = 8'h00;
   logic       req_frame_start = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_joy_x;
   logic [7:0] rsp_joy_y;
   logic [9:0] rsp_accel_x;
   logic [9:0] rsp_accel_y;
   logic [9:0] rsp_accel_z;
   logic       rsp_z_pressed;
   logic       rsp_c_pressed;
   logic       rsp_changed;

   scoreboard_type sb;
   int  bytes_sent = 0;
   int  reports_seen = 0;
   bit  sender_no_gaps = 1'b0;
   logic [7:0] last_frame [6];

   joystick_accel_report_decoder u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_raw_byte    (req_raw_byte),
      .req_frame_start (req_frame_start),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_joy_x       (rsp_joy_x),
      .rsp_joy_y       (rsp_joy_y),
      .rsp_accel_x     (rsp_accel_x),
      .rsp_accel_y     (rsp_accel_y),
      .rsp_accel_z     (rsp_accel_z),
      .rsp_z_pressed   (rsp_z_pressed),
      .rsp_c_pressed   (rsp_c_pressed),
      .rsp_changed     (rsp_changed)
   );

   always #10 clock = ~clock;

   // The raw byte that decodes to a chosen value, for the directed frames.
   function automatic logic [7:0] raw_for(logic [7:0] plain);
      return (plain - jard_pkg::DECODE_KEY) ^ jard_pkg::DECODE_KEY;
   endfunction

   // Offers one byte after a random gap and returns at the edge of its transfer.
   // While the gap runs the payload carries junk, which the block must ignore.
   task automatic send_byte(logic [7:0] raw, logic first);
      int gap;
      gap = sender_no_gaps ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req_valid       <= 1'b0;
         req_raw_byte    <= 8'($urandom);
         req_frame_start <= 1'($urandom);
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_raw_byte    <= raw;
      req_frame_start <= first;
      do @(posedge clock); while (!(req_valid && req_ready));
      bytes_sent++;
   endtask

   // One random frame. Most frames are well formed; half have random content, the rest repeat
   // the previous frame, whole or with one bit flipped, so that the changed flag is
   // seen both ways. A few carry a stray frame start that breaks them up.
   task automatic send_random_frame();
      logic [7:0] frame [6];
      int         style;
      int         pick;
      logic       first;
      style = $urandom_range(0, 9);
      for (int i = 0; i < 6; i++) begin
         pick = $urandom_range(0, 7);
         if (style < 3)
            frame[i] = last_frame[i];
         else if (pick == 0)
            frame[i] = 8'h00;
         else if (pick == 1)
            frame[i] = 8'hFF;
         else
            frame[i] = 8'($urandom);
      end
      if (style >= 3 && style < 5) begin
         frame = last_frame;
         pick = $urandom_range(0, 5);
         frame[pick][$urandom_range(0, 7)] ^= 1'b1;
      end
      for (int i = 0; i < 6; i++) begin
         if (i == 0)
            first = ($urandom_range(0, 3) != 0);
         else
            first = ($urandom_range(0, 49) == 0);
         send_byte(frame[i], first);
      end
      last_frame = frame;
   endtask

   // Reset, then the directed frames, then the random body.
   initial begin
      int partial_len;
      sb = new();
      foreach (last_frame[i]) last_frame[i] = 8'h00;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // The first report is all zero and so matches the cleared previous report.
      for (int i = 0; i < 6; i++) send_byte(raw_for(8'h00), i == 0);
      // A back-to-back frame without a frame start, every field at its maximum.
      for (int i = 0; i < 6; i++) send_byte(raw_for(8'hFF), 1'b0);
      // Five bytes of raw extremes, then a frame start right where the sixth byte
      // would go: the partial frame is dropped and gives no report.
      for (int i = 0; i < 5; i++) send_byte((i % 2) ? 8'hFF : 8'h00, i == 0);
      // The same maximum frame again, so the changed flag stays low.
      for (int i = 0; i < 6; i++) send_byte(raw_for(8'hFF), i == 0);

      while (bytes_sent < 1320) begin
         sender_no_gaps = ($urandom_range(0, 4) == 0);
         if ($urandom_range(0, 9) == 0) begin
            // A broken frame: one to five random bytes, dropped when the next frame opens with a frame start.
            partial_len = $urandom_range(1, 5);
            for (int i = 0; i < partial_len; i++)
               send_byte(8'($urandom), (i == 0) && ($urandom_range(0, 1) == 1));
         end
         send_random_frame();
      end
      req_valid <= 1'b0;

      // Drain, then wait on so that any extra report from the block would show.
      while (sb.expected_reports.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (sb.failures == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   // The response side stalls a random number of cycles before each report, with
   // runs of no stalls now and then. Once, early in the random part, it holds off
   // for a long stretch so that the block fills up and stops taking bytes.
   initial begin
      int  stall;
      int  calm_left;
      bit  long_hold_done;
      calm_left      = 0;
      long_hold_done = 1'b0;
      @(posedge clock);
      forever begin
         if (!long_hold_done && reports_seen >= 60) begin
            stall          = 300;
            long_hold_done = 1'b1;
         end else if (calm_left > 0) begin
            stall = 0;
            calm_left--;
         end else begin
            stall = $urandom_range(0, 8);
            if ($urandom_range(0, 15) == 0) calm_left = 20;
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
      end
   end

   // Both channels are sampled at the rising edge, before this edge's updates land.
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready)
         sb.note_byte(req_raw_byte, req_frame_start);
   end

   always @(posedge clock) begin : watch_reports
      report_type observed;
      if (!reset && rsp_valid && rsp_ready) begin
         observed = {rsp_joy_x, rsp_joy_y, rsp_accel_x, rsp_accel_y, rsp_accel_z,
                     rsp_z_pressed, rsp_c_pressed, rsp_changed};
         sb.check_report(observed);
         reports_seen++;
      end
   end

   // A correct run takes well under a tenth of this.
   initial begin
      #5ms;
      $display("Regression FAIL");
      $finish;
   end

endmodule

`default_nettype wire

[sim.f]
sv/jard_pkg.sv
sv/joystick_accel_report_decoder.sv
sv/jard_checker.sv
test/joystick_accel_report_decoder_tb.sv
